@@ rtl/abrd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and codes for the audio buffer ring dispatcher.
// No dependencies; every other source file depends on this package.
package abrd_pkg;

  localparam int RING_SIZE  = 4;
  localparam int FIFO_DEPTH = 2;

  localparam int IDX_W   = $clog2(RING_SIZE);
  localparam int SLOT_W  = 3;
  localparam int REQ_W   = 2;
  localparam int BUF_W   = 2;
  localparam int FREE_W  = 2;
  localparam int KIND_W  = 3;
  localparam int LEN_W   = 18;
  localparam int ERR_W   = 2;
  localparam int FRAME_W = 16;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [LEN_W-1:0] LEN_MASK = ~LEN_W'(7);
  localparam logic [APB_AW-1:0] REG_BUFFER_FRAMES = APB_AW'(0);

  typedef enum logic [REQ_W-1:0] {
    REQ_ACQUIRE = 2'd0,
    REQ_PLAY    = 2'd1,
    REQ_REFILL  = 2'd2,
    REQ_SPARE   = 2'd3
  } req_type_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_GRANT   = 3'd0,
    KIND_DMA     = 3'd1,
    KIND_BUSY    = 3'd2,
    KIND_PLAY_OK = 3'd3,
    KIND_DONE    = 3'd4
  } result_kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE         = 2'd0,
    ERR_PENDING      = 2'd1,
    ERR_NOT_ACQUIRED = 2'd2
  } error_code_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic emit_dma;
    logic emit_status;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic dma_ok;
  } dp_status_t;

endpackage

@@ rtl/abrd_if.sv @@
`timescale 1ns / 1ps
// Request and result channel interfaces with valid/ready handshake.
// Depends on abrd_pkg for field widths.
interface abrd_req_if;
  logic valid;
  logic ready;
  logic [abrd_pkg::REQ_W-1:0]  req_type;
  logic [abrd_pkg::BUF_W-1:0]  buffer_index;
  logic [abrd_pkg::FREE_W-1:0] fifo_free_slots;

  modport source(output valid, req_type, buffer_index, fifo_free_slots, input ready);
  modport sink(input valid, req_type, buffer_index, fifo_free_slots, output ready);
endinterface

interface abrd_res_if;
  logic valid;
  logic ready;
  logic [abrd_pkg::KIND_W-1:0] result_kind;
  logic [abrd_pkg::BUF_W-1:0]  result_buffer;
  logic [abrd_pkg::LEN_W-1:0]  dma_length_bytes;
  logic [abrd_pkg::ERR_W-1:0]  error_code;
  logic                        last;

  modport source(output valid, result_kind, result_buffer, dma_length_bytes, error_code,
                 last, input ready);
  modport sink(input valid, result_kind, result_buffer, dma_length_bytes, error_code,
               last, output ready);
endinterface

@@ rtl/abrd_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine: takes a request, then steps the datapath through
// its DMA starts and the closing status item. Depends on abrd_pkg.
module abrd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  abrd_pkg::dp_status_t sts,
  output abrd_pkg::dp_cmd_t    cmd
);
  import abrd_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.out_free && !sts.dma_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    cmd.capture     = 1'b0;
    cmd.emit_dma    = 1'b0;
    cmd.emit_status = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_RUN: begin
        cmd.emit_dma    = sts.out_free && sts.dma_ok;
        cmd.emit_status = sts.out_free && !sts.dma_ok;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/abrd_dp.sv @@
`timescale 1ns / 1ps
// Datapath: ring marks, playing index, per-request context and the result
// output register. Driven by abrd_ctrl commands; depends on abrd_pkg.
module abrd_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  abrd_pkg::dp_cmd_t               cmd,
  output abrd_pkg::dp_status_t            sts,
  input  logic [abrd_pkg::REQ_W-1:0]      in_req_type,
  input  logic [abrd_pkg::BUF_W-1:0]      in_buffer_index,
  input  logic [abrd_pkg::FREE_W-1:0]     in_fifo_free_slots,
  input  logic [abrd_pkg::FRAME_W-1:0]    buffer_frames,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic [abrd_pkg::KIND_W-1:0]     res_kind,
  output logic [abrd_pkg::BUF_W-1:0]      res_buffer,
  output logic [abrd_pkg::LEN_W-1:0]      res_length,
  output logic [abrd_pkg::ERR_W-1:0]      res_error,
  output logic                            res_last
);
  import abrd_pkg::*;

  logic [IDX_W-1:0]     playing_index;
  logic [RING_SIZE-1:0] acquired_marks;
  logic [RING_SIZE-1:0] pending_marks;
  req_type_t            req_q;
  logic [BUF_W-1:0]     bi_q;
  logic [SLOT_W-1:0]    slots;
  error_code_t          err_q;

  logic [IDX_W-1:0]  next_idx;
  logic              next_pending;
  logic [IDX_W-1:0]  bi_idx;
  logic              bi_in_ring;
  error_code_t       play_err;
  logic [SLOT_W-1:0] free_ext;
  logic [LEN_W-1:0]  dma_len;

  assign next_idx     = (playing_index == IDX_W'(RING_SIZE - 1)) ? '0
                                                                 : playing_index + 1'b1;
  assign next_pending = pending_marks[next_idx];
  assign bi_in_ring   = {{(32-BUF_W){1'b0}}, in_buffer_index} < RING_SIZE;
  assign bi_idx       = IDX_W'(in_buffer_index);
  assign free_ext     = SLOT_W'(in_fifo_free_slots);
  assign dma_len      = (LEN_W'(buffer_frames) << 2) & LEN_MASK;

  always_comb begin
    priority if (bi_in_ring && pending_marks[bi_idx]) begin
      play_err = ERR_PENDING;
    end else if (!bi_in_ring || !acquired_marks[bi_idx]) begin
      play_err = ERR_NOT_ACQUIRED;
    end else begin
      play_err = ERR_NONE;
    end
  end

  assign sts.out_free = !res_valid || res_ready;
  assign sts.dma_ok   = (slots != '0) && next_pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      playing_index  <= '0;
      acquired_marks <= '0;
      pending_marks  <= '0;
    end else if (cmd.capture) begin
      if (req_type_t'(in_req_type) == REQ_PLAY && play_err == ERR_NONE && bi_in_ring) begin
        acquired_marks[bi_idx] <= 1'b0;
        pending_marks[bi_idx]  <= 1'b1;
      end
    end else if (cmd.emit_dma) begin
      playing_index           <= next_idx;
      pending_marks[next_idx] <= 1'b0;
    end else if (cmd.emit_status) begin
      if (req_q == REQ_ACQUIRE && !next_pending) begin
        acquired_marks[next_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req_type_t'(in_req_type);
      bi_q  <= in_buffer_index;
      err_q <= play_err;
      slots <= (free_ext > SLOT_W'(FIFO_DEPTH)) ? SLOT_W'(FIFO_DEPTH) : free_ext;
    end else if (cmd.emit_dma) begin
      slots <= slots - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit_dma || cmd.emit_status) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_dma) begin
      res_kind   <= KIND_DMA;
      res_buffer <= BUF_W'(next_idx);
      res_length <= dma_len;
      res_error  <= ERR_NONE;
      res_last   <= 1'b0;
    end else if (cmd.emit_status) begin
      res_length <= '0;
      res_last   <= 1'b1;
      unique case (req_q)
        REQ_ACQUIRE: begin
          res_kind   <= next_pending ? KIND_BUSY : KIND_GRANT;
          res_buffer <= BUF_W'(next_idx);
          res_error  <= ERR_NONE;
        end
        REQ_PLAY: begin
          res_kind   <= (err_q == ERR_NONE) ? KIND_PLAY_OK : KIND_DONE;
          res_buffer <= bi_q;
          res_error  <= err_q;
        end
        REQ_REFILL, REQ_SPARE: begin
          res_kind   <= KIND_DONE;
          res_buffer <= BUF_W'(playing_index);
          res_error  <= ERR_NONE;
        end
        default: begin
          res_kind   <= KIND_DONE;
          res_buffer <= BUF_W'(playing_index);
          res_error  <= ERR_NONE;
        end
      endcase
    end
  end

endmodule

@@ rtl/audio_buffer_ring_dispatcher_core.sv @@
`timescale 1ns / 1ps
// Top level of the audio buffer ring dispatcher: APB register, controller and
// datapath. Depends on abrd_pkg, abrd_if, abrd_ctrl and abrd_dp.
//
//   Channel   Direction  Protocol    Carries
//   req       in         valid/ready req_type, buffer_index, fifo_free_slots
//   res       out        valid/ready result_kind, result_buffer, dma_length_bytes,
//                                    error_code, last
//   APB       in         psel/penable buffer_frames at byte address 0
//
// A request is captured, then its result items are loaded one after another
// (up to FIFO_DEPTH DMA starts plus one status item). Results leave through
// a single output register; each item waits there while res.ready is low,
// which holds the controller. The next request is taken once the status item
// has been loaded.
// Reset is synchronous and clears the marks, playing index and buffer_frames.
module audio_buffer_ring_dispatcher_core (
  input  logic                          clk,
  input  logic                          rst,
  abrd_req_if.sink                      req,
  abrd_res_if.source                    res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [abrd_pkg::APB_AW-1:0]   paddr,
  input  logic [abrd_pkg::APB_DW-1:0]   pwdata,
  output logic [abrd_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import abrd_pkg::*;

  logic [FRAME_W-1:0] buffer_frames;
  dp_cmd_t            cmd;
  dp_status_t         sts;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_BUFFER_FRAMES) ? APB_DW'(buffer_frames) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_frames <= '0;
    end else if (psel && penable && pwrite && paddr == REG_BUFFER_FRAMES) begin
      buffer_frames <= pwdata[FRAME_W-1:0];
    end
  end

  abrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  abrd_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .in_req_type        (req.req_type),
    .in_buffer_index    (req.buffer_index),
    .in_fifo_free_slots (req.fifo_free_slots),
    .buffer_frames      (buffer_frames),
    .res_valid          (res.valid),
    .res_ready          (res.ready),
    .res_kind           (res.result_kind),
    .res_buffer         (res.result_buffer),
    .res_length         (res.dma_length_bytes),
    .res_error          (res.error_code),
    .res_last           (res.last)
  );

endmodule

@@ tb/tb_audio_buffer_ring_dispatcher_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the audio buffer ring dispatcher: directed and random
// requests against a cycle-free prediction of grants, DMA starts and status items.
// Depends on abrd_pkg, abrd_if and the audio_buffer_ring_dispatcher_core RTL.
import abrd_pkg::*;

typedef struct packed {
  result_kind_t           kind;
  logic [BUF_W-1:0]       buffer;
  logic [LEN_W-1:0]       length;
  error_code_t            err;
  logic                   last;
} ring_result_t;

class ring_scoreboard;
  logic [FRAME_W-1:0]   frames;
  logic [IDX_W-1:0]     playing;
  logic [RING_SIZE-1:0] acquired;
  logic [RING_SIZE-1:0] pending;
  ring_result_t         due_results[$];
  int                   failures;

  function new();
    frames   = '0;
    playing  = '0;
    acquired = '0;
    pending  = '0;
    failures = 0;
  endfunction

  function logic [IDX_W-1:0] next_buffer();
    return IDX_W'((int'(playing) + 1) % RING_SIZE);
  endfunction

  function int outstanding();
    return due_results.size();
  endfunction

  function void add_due(result_kind_t kind, logic [BUF_W-1:0] buffer,
                        logic [LEN_W-1:0] length, error_code_t err, logic last);
    ring_result_t item;
    item.kind   = kind;
    item.buffer = buffer;
    item.length = length;
    item.err    = err;
    item.last   = last;
    due_results.push_back(item);
  endfunction

  function void run_dispatch(logic [FREE_W-1:0] free_slots);
    int                slots;
    logic [IDX_W-1:0]  nx;
    logic [LEN_W-1:0]  length;
    length = LEN_W'({frames, 2'b00}) & LEN_MASK;
    slots  = (int'(free_slots) > FIFO_DEPTH) ? FIFO_DEPTH : int'(free_slots);
    while (slots > 0) begin
      nx = next_buffer();
      if (!pending[nx]) break;
      add_due(KIND_DMA, BUF_W'(nx), length, ERR_NONE, 1'b0);
      playing     = nx;
      pending[nx] = 1'b0;
      slots--;
    end
  endfunction

  function void note_request(req_type_t rq, logic [BUF_W-1:0] idx,
                             logic [FREE_W-1:0] free_slots);
    logic [IDX_W-1:0] nx;
    error_code_t      err;
    bit               in_ring;
    case (rq)
      REQ_ACQUIRE: begin
        run_dispatch(free_slots);
        nx = next_buffer();
        if (pending[nx]) begin
          add_due(KIND_BUSY, BUF_W'(nx), '0, ERR_NONE, 1'b1);
        end else begin
          acquired[nx] = 1'b1;
          add_due(KIND_GRANT, BUF_W'(nx), '0, ERR_NONE, 1'b1);
        end
      end
      REQ_PLAY: begin
        in_ring = int'(idx) < RING_SIZE;
        err     = ERR_NONE;
        if (in_ring && pending[idx]) err = ERR_PENDING;
        else if (!in_ring || !acquired[idx]) err = ERR_NOT_ACQUIRED;
        if (err == ERR_NONE) begin
          acquired[idx] = 1'b0;
          pending[idx]  = 1'b1;
        end
        run_dispatch(free_slots);
        if (err == ERR_NONE) add_due(KIND_PLAY_OK, idx, '0, ERR_NONE, 1'b1);
        else add_due(KIND_DONE, idx, '0, err, 1'b1);
      end
      default: begin
        run_dispatch(free_slots);
        add_due(KIND_DONE, BUF_W'(playing), '0, ERR_NONE, 1'b1);
      end
    endcase
  endfunction

  function void flag_miss(string what, ring_result_t want, ring_result_t got);
    failures++;
    if (failures <= 10)
      $display({"%0t %s: expected kind=%0d buffer=%0d length=%0d error=%0d last=%0d,",
                " got kind=%0d buffer=%0d length=%0d error=%0d last=%0d"},
               $realtime, what, want.kind, want.buffer, want.length, want.err, want.last,
               got.kind, got.buffer, got.length, got.err, got.last);
  endfunction

  function void check_result(ring_result_t got);
    ring_result_t want;
    if (due_results.size() == 0) begin
      flag_miss("unexpected result", '0, got);
      return;
    end
    want = due_results.pop_front();
    if (got.kind !== want.kind || got.buffer !== want.buffer || got.length !== want.length ||
        got.err !== want.err || got.last !== want.last)
      flag_miss("result mismatch", want, got);
  endfunction
endclass

module tb_audio_buffer_ring_dispatcher_core;
  localparam int QUIET_LIMIT  = 1000;
  localparam int PHASE_ITEMS  = 26;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  abrd_req_if req_ch ();
  abrd_res_if res_ch ();

  ring_scoreboard sb = new();
  bit             idle_on   = 1'b1;
  bit             stalls_on = 1'b1;
  int             stall_left = 0;
  int             quiet_cycles = 0;

  audio_buffer_ring_dispatcher_core DUT (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left--;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      res_ch.ready <= 1'b0;
      stall_left = $urandom_range(0, 9);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    ring_result_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.kind   = result_kind_t'(res_ch.result_kind);
      got.buffer = res_ch.result_buffer;
      got.length = res_ch.dma_length_bytes;
      got.err    = error_code_t'(res_ch.error_code);
      got.last   = res_ch.last;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic issue_request(req_type_t rq, logic [BUF_W-1:0] idx,
                               logic [FREE_W-1:0] free_slots);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.req_type        <= rq;
    req_ch.buffer_index    <= idx;
    req_ch.fifo_free_slots <= free_slots;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(rq, idx, free_slots);
  endtask

  task automatic wait_results_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  task automatic write_frames(logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= REG_BUFFER_FRAMES;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.frames = value[FRAME_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_request();
    int                pick;
    logic [BUF_W-1:0]  idx;
    logic [FREE_W-1:0] free_slots;
    pick       = $urandom_range(0, 9);
    idx        = BUF_W'($urandom_range(0, 3));
    free_slots = FREE_W'($urandom_range(0, 3));
    if (pick <= 2) issue_request(REQ_ACQUIRE, idx, free_slots);
    else if (pick <= 5) issue_request(REQ_PLAY, BUF_W'(sb.next_buffer()), free_slots);
    else if (pick <= 7) issue_request(REQ_REFILL, idx, free_slots);
    else if (pick == 8) issue_request(REQ_PLAY, idx, free_slots);
    else issue_request(req_type_t'(REQ_W'($urandom_range(0, 3))), idx, free_slots);
  endtask

  initial begin
    logic [FRAME_W-1:0] phase_frames [5];
    req_ch.valid           <= 1'b0;
    req_ch.req_type        <= REQ_ACQUIRE;
    req_ch.buffer_index    <= '0;
    req_ch.fifo_free_slots <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    issue_request(REQ_REFILL,  2'd0, 2'd0);
    issue_request(REQ_PLAY,    2'd1, 2'd0);
    issue_request(REQ_PLAY,    2'd0, 2'd3);
    issue_request(REQ_ACQUIRE, 2'd3, 2'd2);
    issue_request(REQ_ACQUIRE, 2'd0, 2'd0);
    issue_request(REQ_PLAY,    2'd2, 2'd0);
    issue_request(REQ_PLAY,    2'd1, 2'd0);
    issue_request(REQ_PLAY,    2'd1, 2'd0);
    issue_request(REQ_ACQUIRE, 2'd2, 2'd0);
    issue_request(REQ_SPARE,   2'd3, 2'd3);
    wait_results_drained();
    write_frames(32'hA5A5_0008);
    issue_request(REQ_ACQUIRE, 2'd1, 2'd1);
    issue_request(REQ_PLAY,    2'd2, 2'd1);
    issue_request(REQ_ACQUIRE, 2'd0, 2'd0);
    issue_request(REQ_PLAY,    2'd3, 2'd0);
    issue_request(REQ_REFILL,  2'd1, 2'd1);
    issue_request(REQ_ACQUIRE, 2'd2, 2'd0);
    issue_request(REQ_PLAY,    2'd0, 2'd0);
    issue_request(REQ_PLAY,    2'd0, 2'd2);
    issue_request(REQ_PLAY,    2'd3, 2'd0);
    issue_request(REQ_REFILL,  2'd2, 2'd3);

    phase_frames[0] = 16'hFFF8;
    phase_frames[1] = 16'hFFFF;
    phase_frames[2] = FRAME_W'($urandom);
    phase_frames[3] = 16'h0000;
    phase_frames[4] = FRAME_W'($urandom) & ~FRAME_W'(7);
    foreach (phase_frames[p]) begin
      wait_results_drained();
      write_frames({16'($urandom), phase_frames[p]});
      if (p == 4) begin
        idle_on   = 1'b0;
        stalls_on = 1'b0;
      end
      repeat (PHASE_ITEMS) random_request();
    end

    wait_results_drained();
    repeat (10) @(posedge clk);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/abrd_pkg.sv
rtl/abrd_if.sv
rtl/abrd_ctrl.sv
rtl/abrd_dp.sv
rtl/audio_buffer_ring_dispatcher_core.sv
tb/tb_audio_buffer_ring_dispatcher_core.sv
